[sv/pfs_pkg.sv]
// Shared types and constants for the PID step unit with setpoint feedforward.
// Used by the front, queue, back and top-level files; depends on nothing.
package pfs_pkg;

    localparam int ResetBandDefault  = 10000;
    localparam int QueueDepthDefault = 2;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_GAIN_P = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_I = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_F = 2'd3;

    localparam logic signed [15:0] GainPReset = 16'sd384;
    localparam logic signed [15:0] GainIReset = 16'sd256;
    localparam logic signed [15:0] GainDReset = 16'sd256;
    localparam logic signed [15:0] GainFReset = 16'sd30720;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [15:0] measured;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] drive;
    } t_out_word;

    typedef struct packed {
        logic signed [15:0] target;
        logic signed [16:0] error;
        logic signed [31:0] integ;
        logic signed [17:0] deriv;
    } t_work;

    typedef struct packed {
        logic signed [15:0] p;
        logic signed [15:0] i;
        logic signed [15:0] d;
        logic signed [15:0] f;
    } t_gains;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

[sv/pfs_stream_if.sv]
// Valid/ready stream interface carrying one word of payload type T.
// Used for the input and result channels of the PID step unit.
interface pfs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[sv/pid_feedforward_step_unit.sv]
// PID step unit with setpoint feedforward: gain registers, front end, queue, back end.
// An accepted input word passes through the queue, the product registers and the
// output register before its result word shows valid; one word is accepted per cycle
// while the output is not stalled, through the two-stage multiply and sum pipeline.
// Reset clears the integral, the previous error, the queue and the pipeline,
// and loads the gains with their default values.
module pid_feedforward_step_unit #(
    parameter int RESET_BAND  = pfs_pkg::ResetBandDefault,
    parameter int QUEUE_DEPTH = pfs_pkg::QueueDepthDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pfs_stream_if.sink                   i_in,
    pfs_stream_if.source                 o_out,
    input  logic                         i_cfg_we,
    input  logic [pfs_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [pfs_pkg::CfgDataW-1:0] i_cfg_wdata
);
    import pfs_pkg::*;

    t_gains        r_gains;
    t_queue_status q_status;
    t_work         push_data;
    t_work         head;
    logic          push;
    logic          pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gains.p <= GainPReset;
            r_gains.i <= GainIReset;
            r_gains.d <= GainDReset;
            r_gains.f <= GainFReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P: begin
                    r_gains.p <= i_cfg_wdata;
                end
                CFG_GAIN_I: begin
                    r_gains.i <= i_cfg_wdata;
                end
                CFG_GAIN_D: begin
                    r_gains.d <= i_cfg_wdata;
                end
                CFG_GAIN_F: begin
                    r_gains.f <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    pfs_front #(
        .RESET_BAND(RESET_BAND)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_data(push_data)
    );

    pfs_queue #(
        .T    (t_work),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    pfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gains   (r_gains),
        .i_head    (head),
        .i_q_status(q_status),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

[sv/pfs_front.sv]
// Front end: accepts input words, forms error, integral and derivative, and
// pushes the work into the queue. Depends on pfs_pkg and pfs_stream_if.
module pfs_front #(
    parameter int RESET_BAND = pfs_pkg::ResetBandDefault
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pfs_stream_if.sink            i_in,
    input  pfs_pkg::t_queue_status i_q_status,
    output logic                  o_push,
    output pfs_pkg::t_work        o_push_data
);
    import pfs_pkg::*;

    localparam logic [16:0] Band = 17'(RESET_BAND);

    logic signed [31:0] r_error_sum;
    logic signed [16:0] r_last_error;
    logic signed [31:0] n_error_sum;

    logic               accept;
    logic signed [16:0] error;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic               clear;
    logic signed [17:0] deriv;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        error    = {i_in.data.target[15], i_in.data.target}
                 - {i_in.data.measured[15], i_in.data.measured};
        sum_wide = {r_error_sum[31], r_error_sum} + {{16{error[16]}}, error};
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
        end else begin
            sum_sat = sum_wide[31:0];
        end
        clear = (error == 17'sd0)
             || (error > $signed({i_in.data.target[15], i_in.data.target}))
             || (!error[16] && ($unsigned(error) < Band));
        n_error_sum = clear ? 32'sd0 : sum_sat;
        deriv = {error[16], error} - {r_last_error[16], r_last_error};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else if (accept) begin
            r_error_sum  <= n_error_sum;
            r_last_error <= error;
        end
    end

    assign o_push             = accept;
    assign o_push_data.target = i_in.data.target;
    assign o_push_data.error  = error;
    assign o_push_data.integ  = n_error_sum;
    assign o_push_data.deriv  = deriv;

endmodule

[sv/pfs_queue.sv]
// Short FIFO of work words between the front end and the back end.
// Depends on pfs_pkg for the status struct.
module pfs_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = pfs_pkg::QueueDepthDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  T                       i_push_data,
    input  logic                   i_pop,
    output T                       o_head,
    output pfs_pkg::t_queue_status o_status
);
    import pfs_pkg::*;

    localparam int AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountW = $clog2(DEPTH + 1);
    localparam logic [AddrW-1:0]  LastAddr = AddrW'(DEPTH - 1);
    localparam logic [CountW-1:0] Full     = CountW'(DEPTH);

    T                  r_mem [DEPTH];
    logic [AddrW-1:0]  r_wr_ptr;
    logic [AddrW-1:0]  r_rd_ptr;
    logic [CountW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == Full);
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastAddr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastAddr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/pfs_back.sv]
// Back end: multiplies the queued work by the gains, sums the scaled
// products with saturation and holds the result word. Depends on pfs_pkg.
module pfs_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pfs_pkg::t_gains        i_gains,
    input  pfs_pkg::t_work         i_head,
    input  pfs_pkg::t_queue_status i_q_status,
    output logic                   o_pop,
    pfs_stream_if.source           o_out
);
    import pfs_pkg::*;

    logic               r_s1_valid;
    logic signed [31:0] r_pf;
    logic signed [32:0] r_pp;
    logic signed [47:0] r_pi;
    logic signed [33:0] r_pd;
    logic               r_out_valid;
    logic signed [31:0] r_drive;

    logic signed [31:0] n_pf;
    logic signed [32:0] n_pp;
    logic signed [47:0] n_pi;
    logic signed [33:0] n_pd;
    logic signed [41:0] sum;
    logic signed [31:0] n_drive;
    logic               advance;

    assign advance = !r_out_valid || o_out.ready;
    assign o_pop   = advance && !i_q_status.empty;

    always_comb begin
        n_pf = 32'(i_head.target) * 32'(i_gains.f);
        n_pp = 33'(i_head.error)  * 33'(i_gains.p);
        n_pi = 48'(i_head.integ)  * 48'(i_gains.i);
        n_pd = 34'(i_head.deriv)  * 34'(i_gains.d);
        sum  = 42'(r_pf >>> 8) + 42'(r_pp >>> 8) + 42'(r_pi >>> 8) + 42'(r_pd >>> 8);
        if ((&sum[41:31]) || !(|sum[41:31])) begin
            n_drive = sum[31:0];
        end else begin
            n_drive = sum[41] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pf <= n_pf;
            r_pp <= n_pp;
            r_pi <= n_pi;
            r_pd <= n_pd;
        end
        if (advance && r_s1_valid) begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= !i_q_status.empty;
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.data.drive = r_drive;

endmodule

[sv/pfs_checker.sv]
// Port-level checks for the PID step unit, bound to the top level.
// Depends only on the top level's ports.
module pfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_drive
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_drive))
        else $error("stalled result word changed");

    a_ready_follows_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_ready) |-> i_in_ready)
        else $error("input not ready although the output drained");

    a_valid_drops_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_out_valid) |-> $past(i_out_ready))
        else $error("result dropped without being taken");

endmodule

bind pid_feedforward_step_unit pfs_checker u_pfs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_ready (i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_drive(o_out.data.drive)
);

[verif/pid_feedforward_step_unit_tb.sv]
// Self-checking testbench for pid_feedforward_step_unit: directed table, random words,
// output hold-off, drain pause and short windup runs, checked by a local predictor or
// a drive given in the table. Depends on pfs_pkg, pfs_stream_if and the unit itself.
module pid_feedforward_step_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfs_pkg::*;

    localparam int ResetBand     = ResetBandDefault;
    localparam int LatencyCycles = 2;
    localparam int RxHoldCycles  = 80;
    localparam longint S32Max    = 64'sd2147483647;
    localparam longint S32Min    = -64'sd2147483648;

    localparam logic signed [15:0] GainMax = 16'sh7FFF;
    localparam logic signed [15:0] GainMin = 16'sh8000;

    localparam t_gains GainsReset = '{GainPReset, GainIReset, GainDReset, GainFReset};
    localparam t_gains GainsMax   = '{GainMax, GainMax, GainMax, GainMax};
    localparam t_gains GainsMin   = '{GainMin, GainMin, GainMin, GainMin};

    typedef enum logic {ROW_GAINS, ROW_WORD} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        t_gains             gains;
        t_in_word           word;
        logic               has_drive;
        logic signed [31:0] drive;
    } t_row;

    localparam int NumRows = 25;
    localparam t_row DirectedRows [NumRows] = '{
        '{ROW_WORD,  '0,         '{16'sd0,     16'sd0},     1'b1, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh7FFF,  16'sh8000},  1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh8000,  16'sh7FFF},  1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh8000,  16'sh8000},  1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh7FFF,  16'sh7FFF},  1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd10000, 16'sd1},     1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd10000, 16'sd0},     1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd100,   -16'sd9900}, 1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd0,     16'sd1},     1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{-16'sd5,    -16'sd4},    1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd1,     16'sd0},     1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd32767, 16'sd0},     1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd32767, 16'sd22767}, 1'b0, 32'sd0},
        '{ROW_GAINS, '0,         '0,                        1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd12345, -16'sd321},  1'b1, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh8000,  16'sh7FFF},  1'b1, 32'sd0},
        '{ROW_GAINS, GainsMax,   '0,                        1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd32767, 16'sd0},     1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh8000,  16'sh7FFF},  1'b0, 32'sd0},
        '{ROW_GAINS, GainsMin,   '0,                        1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh7FFF,  16'sh8000},  1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sh8000,  16'sh8000},  1'b0, 32'sd0},
        '{ROW_GAINS, GainsReset, '0,                        1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{16'sd0,     -16'sd1},    1'b0, 32'sd0},
        '{ROW_WORD,  '0,         '{-16'sd1,    16'sd0},     1'b0, 32'sd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_wdata;

    pfs_stream_if #(.T(t_in_word))  in_if();
    pfs_stream_if #(.T(t_out_word)) out_if();

    pid_feedforward_step_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    t_gains             gain_now;
    logic signed [31:0] integ_acc;
    logic signed [16:0] prev_err;
    logic signed [31:0] pending_drive [$];
    logic signed [31:0] want_drive;

    bit tx_gaps_on;
    bit rx_stalls_on;
    bit rx_hold_req;

    int mismatches;
    int words_checked;
    int gain_sets;
    int integ_clamps;
    int integ_clears;
    int drive_clamps;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp_s32(input longint v);
        if (v > S32Max) return S32Max;
        if (v < S32Min) return S32Min;
        return v;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Advances the integral and previous error, returns the drive for this word.
    function automatic logic signed [31:0] next_drive(input t_in_word w);
        longint tgt, err, acc, slope, total, clamped;
        tgt = longint'($signed(w.target));
        err = tgt - longint'($signed(w.measured));
        acc = clamp_s32(longint'(integ_acc) + err);
        if (acc != longint'(integ_acc) + err) integ_clamps++;
        if (err == 0 || err > tgt || (err > 0 && err < ResetBand)) begin
            acc = 0;
            integ_clears++;
        end
        slope = err - longint'(prev_err);
        prev_err = err[16:0];
        integ_acc = acc[31:0];
        total = ((tgt * longint'($signed(gain_now.f))) >>> 8)
              + ((err * longint'($signed(gain_now.p))) >>> 8)
              + ((acc * longint'($signed(gain_now.i))) >>> 8)
              + ((slope * longint'($signed(gain_now.d))) >>> 8);
        clamped = clamp_s32(total);
        if (clamped != total) drive_clamps++;
        return clamped[31:0];
    endfunction

    function automatic t_gains pick_gains();
        logic signed [15:0] g [4];
        t_gains r;
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
                0: g[k] = GainMax;
                1: g[k] = GainMin;
                2: g[k] = '0;
                default: g[k] = 16'($urandom);
            endcase
        end
        r.p = g[0];
        r.i = g[1];
        r.d = g[2];
        r.f = g[3];
        return r;
    endfunction

    function automatic int pick_edge();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return 32767;
        endcase
    endfunction

    // Mix of fully random words, words that wind the integral up or down,
    // words around the clearing band, zero error and field extremes.
    function automatic t_in_word rand_word();
        int t, m, e;
        t_in_word w;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                t = $urandom;
                m = $urandom;
            end
            3, 4: begin
                t = $urandom_range(ResetBand, 32767);
                m = $urandom_range(0, t - ResetBand);
            end
            5, 6: begin
                m = $urandom_range(1, 32767);
                t = int'($urandom_range(0, m + 32767)) - 32768;
            end
            7: begin
                t = $urandom_range(ResetBand + 1, 32766);
                if ($urandom_range(0, 1) == 0) e = int'($urandom_range(0, 2)) - 1;
                else e = ResetBand + int'($urandom_range(0, 2)) - 1;
                m = t - e;
            end
            8: begin
                t = $urandom;
                m = t;
            end
            default: begin
                t = pick_edge();
                m = pick_edge();
            end
        endcase
        w.target = 16'(t);
        w.measured = 16'(m);
        return w;
    endfunction

    task automatic push_word(input t_in_word w, input bit has_drive,
                             input logic signed [31:0] drive);
        logic signed [31:0] predicted;
        in_if.valid <= 1'b1;
        in_if.data <= w;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = next_drive(w);
        pending_drive.push_back(has_drive ? drive : predicted);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat (gap_len()) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge i_clk);
        repeat (LatencyCycles + 2) @(posedge i_clk);
    endtask

    task automatic write_gains(input t_gains g);
        logic [CfgIdxW-1:0] regs [4];
        logic [CfgDataW-1:0] vals [4];
        regs = '{CFG_GAIN_P, CFG_GAIN_I, CFG_GAIN_D, CFG_GAIN_F};
        vals = '{g.p, g.i, g.d, g.f};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        gain_now = g;
        gain_sets++;
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                stall_left = RxHoldCycles;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = gap_len() - 1;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_drive.size() == 0) begin
                $display("%0t ns: drive word %0d arrived with none expected",
                         $time, out_if.data.drive);
                mismatches++;
            end else begin
                want_drive = pending_drive.pop_front();
                words_checked++;
                if (out_if.data.drive !== want_drive) begin
                    $display("%0t ns: drive mismatch, expected %0d, actual %0d",
                             $time, want_drive, out_if.data.drive);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d words still expected.", pending_drive.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        t_in_word w;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_GAIN_P;
        i_cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        gain_now = GainsReset;
        integ_acc = '0;
        prev_err = '0;
        tx_gaps_on = 1'b1;
        rx_stalls_on = 1'b1;
        rx_hold_req = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NumRows; k++) begin
            if (DirectedRows[k].kind == ROW_GAINS) begin
                wait_idle();
                write_gains(DirectedRows[k].gains);
            end else begin
                push_word(DirectedRows[k].word, DirectedRows[k].has_drive,
                          DirectedRows[k].drive);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_gains(pick_gains());
            tx_gaps_on = (ph != 2);
            rx_stalls_on = (ph != 2);
            for (int n = 0; n < 135; n++) begin
                if (ph == 1 && n == 50) begin
                    tx_gaps_on = 1'b0;
                    rx_hold_req = 1'b1;
                end
                if (ph == 1 && n == 90) tx_gaps_on = 1'b1;
                if (ph == 1 && n == 120) wait_idle();
                push_word(rand_word(), 1'b0, '0);
            end
        end

        // Wind the integral up and then down with the gains at their extremes.
        wait_idle();
        write_gains(GainsMax);
        tx_gaps_on = 1'b0;
        rx_stalls_on = 1'b0;
        push_word('0, 1'b0, '0);
        for (int n = 0; n < 20; n++) begin
            w.target = 16'sd32767;
            w.measured = 16'($urandom_range(0, 100));
            push_word(w, 1'b0, '0);
        end
        push_word('0, 1'b0, '0);
        wait_idle();
        write_gains(GainsMin);
        for (int n = 0; n < 20; n++) begin
            w.target = 16'sh8000;
            w.measured = 16'(32767 - int'($urandom_range(0, 100)));
            push_word(w, 1'b0, '0);
        end

        wait_idle();
        if (pending_drive.size() != 0) begin
            $display("%0t ns: %0d drive words never arrived", $time, pending_drive.size());
            mismatches++;
        end
        $display("Checked %0d drive words over %0d gain settings, with a long output hold-off,",
                 words_checked, gain_sets);
        $display("a drain pause, %0d integral clears, %0d integral and %0d drive clamps.",
                 integ_clears, integ_clamps, drive_clamps);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[sim.f]
sv/pfs_pkg.sv
sv/pfs_stream_if.sv
sv/pfs_front.sv
sv/pfs_queue.sv
sv/pfs_back.sv
sv/pid_feedforward_step_unit.sv
sv/pfs_checker.sv
verif/pid_feedforward_step_unit_tb.sv
